// ===== hw/rtl/ihs_pkg.sv =====
package ihs_pkg;

  // Width of the byte position counter (saturating)
  localparam int POSITION_BITS = 32;

  // Number of leading file bytes kept for header decode
  localparam int HDR_LEN      = 29;
  localparam int HDR_IDX_BITS = $clog2(HDR_LEN);

  // Format codes reported in format_code
  localparam logic [2:0] FMT_UNKNOWN = 3'd0;
  localparam logic [2:0] FMT_PNG     = 3'd1;
  localparam logic [2:0] FMT_BMP     = 3'd2;
  localparam logic [2:0] FMT_DDS     = 3'd3;
  localparam logic [2:0] FMT_TGA     = 3'd4;
  localparam logic [2:0] FMT_JPEG    = 3'd5;

  // JPEG marker scanner phases; the unused codes idle like PH_DONE
  typedef enum logic [3:0] {
    PH_SEARCH   = 4'd0,
    PH_APP_HI   = 4'd1,
    PH_APP_LO   = 4'd2,
    PH_SKIP     = 4'd3,
    PH_SCAN     = 4'd4,
    PH_TYPE     = 4'd5,
    PH_SEG_HI   = 4'd6,
    PH_SEG_LO   = 4'd7,
    PH_SOF_PAD  = 4'd8,
    PH_SOF_READ = 4'd9,
    PH_DONE     = 4'd10
  } ihs_phase_t;

  // JPEG marker bytes
  localparam logic [7:0] JPG_MARK = 8'hFF;
  localparam logic [7:0] JPG_SOI  = 8'hD8;
  localparam logic [7:0] JPG_APP0 = 8'hE0;
  localparam logic [7:0] JPG_SOF0 = 8'hC0;
  localparam logic [7:0] JPG_SOF3 = 8'hC3;

  // Input beat payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } ihs_byte_t;

  // Result beat payload
  typedef struct packed {
    logic        found;
    logic [2:0]  format_code;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [31:0] bit_depth;
  } ihs_result_t;

  // JPEG scanner status, already including the byte being processed
  typedef struct packed {
    logic        done;
    logic [15:0] height;
    logic [15:0] width;
    logic [7:0]  comps;
  } ihs_jpeg_t;

endpackage

// ===== hw/rtl/ihs_byte_if.sv =====
interface ihs_byte_if;
  logic              valid;
  logic              ready;
  ihs_pkg::ihs_byte_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/ihs_result_if.sv =====
interface ihs_result_if;
  logic                valid;
  logic                ready;
  ihs_pkg::ihs_result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/ihs_jpeg_scan.sv =====
module ihs_jpeg_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                restart,
  input  logic [7:0]          data_byte,
  output ihs_pkg::ihs_jpeg_t  status
);
  import ihs_pkg::*;

  ihs_phase_t  phase, phase_next;
  logic [15:0] skip_count, skip_count_next;
  logic [7:0]  length_high, length_high_next;
  logic [39:0] fields, fields_next;
  logic        done, done_next;
  logic [23:0] recent;

  logic [15:0] seg_len;
  logic [15:0] seg_skip;

  // segment length with values under 2 treated as 2
  assign seg_len  = {length_high, data_byte};
  assign seg_skip = (seg_len < 16'd2) ? 16'd0 : seg_len - 16'd2;

  // next state of the marker walk
  always_comb begin
    phase_next       = phase;
    skip_count_next  = skip_count;
    length_high_next = length_high;
    fields_next      = fields;
    done_next        = done;
    case (phase)
      PH_SEARCH: begin
        if (recent == {JPG_MARK, JPG_SOI, JPG_MARK} && data_byte == JPG_APP0) begin
          phase_next = PH_APP_HI;
        end
      end
      PH_APP_HI: begin
        length_high_next = data_byte;
        phase_next       = PH_APP_LO;
      end
      PH_SEG_HI: begin
        length_high_next = data_byte;
        phase_next       = PH_SEG_LO;
      end
      PH_APP_LO, PH_SEG_LO: begin
        skip_count_next = seg_skip;
        phase_next      = (seg_skip == 16'd0) ? PH_SCAN : PH_SKIP;
      end
      PH_SKIP: begin
        skip_count_next = skip_count - 16'd1;
        if (skip_count == 16'd1) begin
          phase_next = PH_SCAN;
        end
      end
      PH_SCAN: begin
        if (data_byte == JPG_MARK) begin
          phase_next = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (data_byte >= JPG_SOF0 && data_byte <= JPG_SOF3) begin
          skip_count_next = 16'd3;
          phase_next      = PH_SOF_PAD;
        end else begin
          phase_next = PH_SEG_HI;
        end
      end
      PH_SOF_PAD: begin
        skip_count_next = skip_count - 16'd1;
        if (skip_count == 16'd1) begin
          phase_next = PH_SOF_READ;
        end
      end
      PH_SOF_READ: begin
        // height, width, component count shift in big-endian
        fields_next     = {fields[31:0], data_byte};
        skip_count_next = skip_count + 16'd1;
        if (skip_count >= 16'd4) begin
          done_next  = 1'b1;
          phase_next = PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  // scanner registers; a last byte returns them to reset values
  always_ff @(posedge clk) begin
    if (rst || (step && restart)) begin
      phase       <= PH_SEARCH;
      skip_count  <= '0;
      length_high <= '0;
      fields      <= '0;
      done        <= 1'b0;
      recent      <= '0;
    end else if (step) begin
      phase       <= phase_next;
      skip_count  <= skip_count_next;
      length_high <= length_high_next;
      fields      <= fields_next;
      done        <= done_next;
      recent      <= {recent[15:0], data_byte};
    end
  end

  // status including the current byte
  always_comb begin
    status.done   = done_next;
    status.height = fields_next[39:24];
    status.width  = fields_next[23:8];
    status.comps  = fields_next[7:0];
  end

endmodule

// ===== hw/rtl/image_header_sniffer_core.sv =====
// Channel  Dir  Beat payload                                          Handshake
// stream   in   data_byte[7:0], last_byte                             valid/ready
// report   out  found, format_code[2:0], image_width[31:0],           valid/ready
//               image_height[31:0], bit_depth[31:0]
//
// One byte per cycle sustained unless a last byte stalls. A byte is held in the input
// register, then the position counter, header store and JPEG scanner update in a single pass.
// A last byte produces one report beat, through the input register and then the report register.
// Reset (rst, synchronous) clears the counter, scanner and both valid flags.
// Only a last byte waits on a full report register; other bytes never stall.
module image_header_sniffer_core (
  input logic         clk,
  input logic         rst,
  ihs_byte_if.sink    stream,
  ihs_result_if.source report
);
  import ihs_pkg::*;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // output register
  logic        out_valid;
  ihs_result_t out_data;
  ihs_result_t result_next;

  logic [POSITION_BITS-1:0] position;
  logic [7:0]               hdr [HDR_LEN];
  logic [7:0]               hb  [HDR_LEN];
  logic                     proc;
  ihs_jpeg_t                jpeg;

  // advance the stage unless a last byte meets a full report register
  assign proc         = in_valid && (!in_last || !out_valid || report.ready);
  assign stream.ready = !in_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (stream.ready) begin
      in_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      in_byte <= stream.payload.data_byte;
      in_last <= stream.payload.last_byte;
    end
  end

  // saturating byte position, cleared after each file
  always_ff @(posedge clk) begin
    if (rst || (proc && in_last)) begin
      position <= '0;
    end else if (proc && position != '1) begin
      position <= position + 1'b1;
    end
  end

  // header store: first bytes of the file
  always_ff @(posedge clk) begin
    if (proc && position < POSITION_BITS'(HDR_LEN)) begin
      hdr[position[HDR_IDX_BITS-1:0]] <= in_byte;
    end
  end

  // header view with the current byte merged in
  always_comb begin
    for (int i = 0; i < HDR_LEN; i++) begin
      hb[i] = (position == POSITION_BITS'(i)) ? in_byte : hdr[i];
    end
  end

  ihs_jpeg_scan u_jpeg (
    .clk       (clk),
    .rst       (rst),
    .step      (proc),
    .restart   (in_last),
    .data_byte (in_byte),
    .status    (jpeg)
  );

  // format decision, in priority order PNG, BMP, DDS, TGA, JPEG
  always_comb begin
    logic [31:0] dep;
    logic [2:0]  fmt;
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] d;
    logic        png_ok;
    dep    = 32'(hb[24]);
    fmt    = FMT_UNKNOWN;
    w      = '0;
    h      = '0;
    d      = '0;
    png_ok = 1'b1;
    if (position >= POSITION_BITS'(2)) begin
      if (hb[0] == 8'd137 && hb[1] == 8'd80 && hb[2] == 8'd78 &&
          position >= POSITION_BITS'(25)) begin
        case (hb[25])
          8'd0:    d = dep;
          8'd2:    d = dep + (dep << 1);
          8'd3:    d = 32'd8;
          8'd4:    d = dep << 1;
          8'd6:    d = dep << 2;
          default: png_ok = 1'b0;
        endcase
        if (png_ok) begin
          fmt = FMT_PNG;
          w   = {hb[16], hb[17], hb[18], hb[19]};
          h   = {hb[20], hb[21], hb[22], hb[23]};
        end else begin
          d = '0;
        end
      end
      if (fmt == FMT_UNKNOWN && hb[0] == 8'd66 && hb[1] == 8'd77 &&
          position >= POSITION_BITS'(28)) begin
        fmt = FMT_BMP;
        w   = {16'd0, hb[19], hb[18]};
        h   = {16'd0, hb[23], hb[22]};
        d   = 32'(hb[28]);
      end
      if (fmt == FMT_UNKNOWN && position >= POSITION_BITS'(27) && hb[0] == 8'd68 &&
          hb[1] == 8'd68 && hb[2] == 8'd83 && hb[3] == 8'd32) begin
        fmt = FMT_DDS;
        h   = {hb[15], hb[14], hb[13], hb[12]};
        w   = {hb[19], hb[18], hb[17], hb[16]};
        d   = {hb[27], hb[26], hb[25], hb[24]};
      end
      if (fmt == FMT_UNKNOWN && hb[0] == 8'd0 && hb[1] == 8'd0 && hb[2] == 8'd2 &&
          position >= POSITION_BITS'(17)) begin
        fmt = FMT_TGA;
        w   = {16'd0, hb[13], hb[12]};
        h   = {16'd0, hb[15], hb[14]};
        d   = 32'(hb[16]);
      end
      if (fmt == FMT_UNKNOWN && jpeg.done) begin
        fmt = FMT_JPEG;
        h   = 32'(jpeg.height);
        w   = 32'(jpeg.width);
        d   = {21'd0, jpeg.comps, 3'd0};
      end
    end
    result_next.found        = (fmt != FMT_UNKNOWN);
    result_next.format_code  = fmt;
    result_next.image_width  = w;
    result_next.image_height = h;
    result_next.bit_depth    = d;
  end

  // report register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && in_last) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && in_last) begin
      out_data <= result_next;
    end
  end

  assign report.valid   = out_valid;
  assign report.payload = out_data;

endmodule

// ===== hw/rtl/ihs_checker.sv =====
module ihs_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input ihs_pkg::ihs_result_t out_payload
);
  import ihs_pkg::*;

  // a stalled report beat stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("report beat dropped while stalled");

  // a stalled report beat keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_payload))
    else $error("report payload changed while stalled");

  // nothing is reported right after reset
  a_reset_idle: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("report beat right after reset");

  // found agrees with the format code, which stays in range
  a_found_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_payload.found == (out_payload.format_code != FMT_UNKNOWN)) &&
                  (out_payload.format_code <= FMT_JPEG))
    else $error("found and format code disagree");

  // an unrecognized file reports zero width, height and bit depth
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_payload.found |->
      out_payload.image_width == 32'd0 && out_payload.image_height == 32'd0 &&
      out_payload.bit_depth == 32'd0)
    else $error("nonzero fields on unknown format");

endmodule

bind image_header_sniffer_core ihs_checker u_ihs_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (report.valid),
  .out_ready   (report.ready),
  .out_payload (report.payload)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import ihs_pkg::*;

  // File signatures and PNG colour types
  localparam logic [7:0] PNG_SIG0 = 8'd137;
  localparam logic [7:0] PNG_SIG1 = 8'd80;
  localparam logic [7:0] PNG_SIG2 = 8'd78;
  localparam logic [7:0] BMP_SIG0 = 8'd66;
  localparam logic [7:0] BMP_SIG1 = 8'd77;
  localparam logic [7:0] DDS_SIG0 = 8'd68;
  localparam logic [7:0] DDS_SIG2 = 8'd83;
  localparam logic [7:0] DDS_SIG3 = 8'd32;
  localparam logic [7:0] TGA_RGB  = 8'd2;

  localparam logic [7:0] PNG_GRAY       = 8'd0;
  localparam logic [7:0] PNG_RGB        = 8'd2;
  localparam logic [7:0] PNG_PALETTE    = 8'd3;
  localparam logic [7:0] PNG_GRAY_ALPHA = 8'd4;
  localparam logic [7:0] PNG_RGBA       = 8'd6;

  localparam int RANDOM_ITEMS = 1850;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 10;

  logic clk;
  logic rst;

  ihs_byte_if   stream_if ();
  ihs_result_if report_if ();

  image_header_sniffer_core dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .report (report_if)
  );

  // Stimulus and scoreboard storage
  ihs_byte_t   pending_bytes[$];
  ihs_result_t expected_reports[$];
  logic [7:0]  file_bytes[$];

  int mismatches;
  int reports_seen;
  int stream_gap;
  int stream_calm;
  int report_hold;
  int report_calm;
  int stall_draw;
  int idle_cycles;

  // Predicted sniffer state
  logic [31:0] file_pos;
  logic [7:0]  file_head[HDR_LEN];
  logic [23:0] last3;
  ihs_phase_t  scan_phase;
  logic [15:0] skip_left;
  logic [7:0]  seg_len_hi;
  logic [39:0] sof_fields;
  logic        sof_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    stream_if.valid = 1'b0;
    stream_if.payload = '0;
    report_if.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  task automatic clear_sniff_state();
    file_pos = '0;
    foreach (file_head[i]) file_head[i] = '0;
    last3 = '0;
    scan_phase = PH_SEARCH;
    skip_left = '0;
    seg_len_hi = '0;
    sof_fields = '0;
    sof_seen = 1'b0;
  endtask

  function automatic logic [31:0] head_le16(input int at);
    return {16'd0, file_head[at + 1], file_head[at]};
  endfunction

  function automatic logic [31:0] head_le32(input int at);
    return {file_head[at + 3], file_head[at + 2], file_head[at + 1], file_head[at]};
  endfunction

  function automatic logic [31:0] head_be32(input int at);
    return {file_head[at], file_head[at + 1], file_head[at + 2], file_head[at + 3]};
  endfunction

  // JPEG marker walk, one byte per call
  task automatic scan_jpeg(input logic [7:0] b);
    logic [15:0] seg_len;
    case (scan_phase)
      PH_SEARCH: begin
        if (last3 == {JPG_MARK, JPG_SOI, JPG_MARK} && b == JPG_APP0)
          scan_phase = PH_APP_HI;
      end
      PH_APP_HI: begin
        seg_len_hi = b;
        scan_phase = PH_APP_LO;
      end
      PH_SEG_HI: begin
        seg_len_hi = b;
        scan_phase = PH_SEG_LO;
      end
      PH_APP_LO, PH_SEG_LO: begin
        seg_len = {seg_len_hi, b};
        if (seg_len < 16'd2) seg_len = 16'd2;
        skip_left = seg_len - 16'd2;
        if (skip_left == 0) scan_phase = PH_SCAN;
        else scan_phase = PH_SKIP;
      end
      PH_SKIP: begin
        skip_left--;
        if (skip_left == 0) scan_phase = PH_SCAN;
      end
      PH_SCAN: begin
        if (b == JPG_MARK) scan_phase = PH_TYPE;
      end
      PH_TYPE: begin
        if (b >= JPG_SOF0 && b <= JPG_SOF3) begin
          skip_left = 16'd3;
          scan_phase = PH_SOF_PAD;
        end else begin
          scan_phase = PH_SEG_HI;
        end
      end
      PH_SOF_PAD: begin
        skip_left--;
        if (skip_left == 0) scan_phase = PH_SOF_READ;
      end
      PH_SOF_READ: begin
        sof_fields = {sof_fields[31:0], b};
        skip_left++;
        if (skip_left >= 16'd5) begin
          sof_seen = 1'b1;
          scan_phase = PH_DONE;
        end
      end
      default: ;
    endcase
  endtask

  // Advance on one accepted byte; a last byte queues the expected report
  task automatic sniff_byte(input logic [7:0] b, input logic is_last);
    logic [32:0] file_len;
    logic [31:0] dep;
    logic        ok;
    ihs_result_t r;
    if (file_pos < HDR_LEN) file_head[file_pos] = b;
    scan_jpeg(b);
    last3 = {last3[15:0], b};
    file_len = {1'b0, file_pos} + 33'd1;
    if (file_pos != '1) file_pos++;
    if (is_last) begin
      r = '0;
      if (file_len >= 3) begin
        if (file_head[0] == PNG_SIG0 && file_head[1] == PNG_SIG1 &&
            file_head[2] == PNG_SIG2 && file_len >= 26) begin
          dep = {24'd0, file_head[24]};
          ok = 1'b1;
          case (file_head[25])
            PNG_GRAY:       r.bit_depth = dep;
            PNG_RGB:        r.bit_depth = dep * 3;
            PNG_PALETTE:    r.bit_depth = 32'd8;
            PNG_GRAY_ALPHA: r.bit_depth = dep * 2;
            PNG_RGBA:       r.bit_depth = dep * 4;
            default:        ok = 1'b0;
          endcase
          if (ok) begin
            r.format_code = FMT_PNG;
            r.image_width = head_be32(16);
            r.image_height = head_be32(20);
          end
        end
        if (r.format_code == FMT_UNKNOWN && file_head[0] == BMP_SIG0 &&
            file_head[1] == BMP_SIG1 && file_len >= 29) begin
          r.format_code = FMT_BMP;
          r.image_width = head_le16(18);
          r.image_height = head_le16(22);
          r.bit_depth = {24'd0, file_head[28]};
        end
        if (r.format_code == FMT_UNKNOWN && file_len >= 28 && file_head[0] == DDS_SIG0 &&
            file_head[1] == DDS_SIG0 && file_head[2] == DDS_SIG2 &&
            file_head[3] == DDS_SIG3) begin
          r.format_code = FMT_DDS;
          r.image_height = head_le32(12);
          r.image_width = head_le32(16);
          r.bit_depth = head_le32(24);
        end
        if (r.format_code == FMT_UNKNOWN && file_head[0] == 8'd0 && file_head[1] == 8'd0 &&
            file_head[2] == TGA_RGB && file_len >= 18) begin
          r.format_code = FMT_TGA;
          r.image_width = head_le16(12);
          r.image_height = head_le16(14);
          r.bit_depth = {24'd0, file_head[16]};
        end
        if (r.format_code == FMT_UNKNOWN && sof_seen) begin
          r.format_code = FMT_JPEG;
          r.image_height = {16'd0, sof_fields[39:24]};
          r.image_width = {16'd0, sof_fields[23:8]};
          r.bit_depth = {21'd0, sof_fields[7:0], 3'd0};
        end
      end
      r.found = (r.format_code != FMT_UNKNOWN);
      expected_reports.push_back(r);
      clear_sniff_state();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("report %0d %s: got 0x%0h, expected 0x%0h",
                                reports_seen, name, got, want));
  endtask

  task automatic check_report(input ihs_result_t got);
    ihs_result_t want;
    if (expected_reports.size() == 0) begin
      report_mismatch($sformatf("report %0d arrived with no file end pending", reports_seen));
    end else begin
      want = expected_reports.pop_front();
      compare_field("found", {31'd0, got.found}, {31'd0, want.found});
      compare_field("format_code", {29'd0, got.format_code}, {29'd0, want.format_code});
      compare_field("image_width", got.image_width, want.image_width);
      compare_field("image_height", got.image_height, want.image_height);
      compare_field("bit_depth", got.bit_depth, want.bit_depth);
    end
    reports_seen++;
  endtask

  // Idle draw per beat, with occasional stretches of back-to-back traffic
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(30, 150);
    return $urandom_range(0, 9);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  task automatic push_file();
    ihs_byte_t beat;
    foreach (file_bytes[i]) begin
      beat.data_byte = file_bytes[i];
      beat.last_byte = (i == file_bytes.size() - 1);
      pending_bytes.push_back(beat);
    end
  endtask

  // Big-endian length word followed by the body it covers
  task automatic push_segment();
    logic [15:0] seg_len;
    case ($urandom_range(0, 19))
      0, 1, 2: seg_len = 16'($urandom_range(0, 2));
      3:       seg_len = 16'($urandom_range(100, 600));
      default: seg_len = 16'($urandom_range(2, 20));
    endcase
    file_bytes.push_back(seg_len[15:8]);
    file_bytes.push_back(seg_len[7:0]);
    if (seg_len > 16'd2) repeat (seg_len - 16'd2) file_bytes.push_back(8'($urandom));
  endtask

  // Junk, SOI + APP0, a few other segments, then an SOF and some trailer
  task automatic append_jpeg_stream();
    logic [7:0] seg_kind;
    repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom));
    file_bytes.push_back(JPG_MARK);
    file_bytes.push_back(JPG_SOI);
    file_bytes.push_back(JPG_MARK);
    file_bytes.push_back(JPG_APP0);
    push_segment();
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom_range(0, 254)));
      file_bytes.push_back(JPG_MARK);
      seg_kind = 8'($urandom);
      if (seg_kind >= JPG_SOF0 && seg_kind <= JPG_SOF3) seg_kind = JPG_APP0;
      file_bytes.push_back(seg_kind);
      push_segment();
    end
    repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom_range(0, 254)));
    file_bytes.push_back(JPG_MARK);
    file_bytes.push_back(8'(JPG_SOF0 + $urandom_range(0, 3)));
    repeat (8) file_bytes.push_back(8'($urandom));
    repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom));
  endtask

  task automatic build_random_file();
    int kind;
    int sig_len;
    int need;
    int n;
    int cut;
    file_bytes = {};
    kind = $urandom_range(0, 9);
    if (kind <= 3) begin
      // headered formats: random body, signature on top, sometimes too short
      case (kind)
        0:       begin sig_len = 3; need = 26; end
        1:       begin sig_len = 2; need = 29; end
        2:       begin sig_len = 4; need = 28; end
        default: begin sig_len = 3; need = 18; end
      endcase
      if ($urandom_range(0, 4) == 0) n = $urandom_range(sig_len, need - 1);
      else n = $urandom_range(need, need + 12);
      repeat (n) file_bytes.push_back(8'($urandom));
      case (kind)
        0: begin
          file_bytes[0] = PNG_SIG0;
          file_bytes[1] = PNG_SIG1;
          file_bytes[2] = PNG_SIG2;
          if (n >= 26) begin
            if ($urandom_range(0, 3) != 0) file_bytes[24] = 8'(1 << $urandom_range(0, 4));
            case ($urandom_range(0, 5))
              0: file_bytes[25] = PNG_GRAY;
              1: file_bytes[25] = PNG_RGB;
              2: file_bytes[25] = PNG_PALETTE;
              3: file_bytes[25] = PNG_GRAY_ALPHA;
              4: file_bytes[25] = PNG_RGBA;
              default: ;
            endcase
          end
        end
        1: begin
          file_bytes[0] = BMP_SIG0;
          file_bytes[1] = BMP_SIG1;
        end
        2: begin
          file_bytes[0] = DDS_SIG0;
          file_bytes[1] = DDS_SIG0;
          file_bytes[2] = DDS_SIG2;
          file_bytes[3] = DDS_SIG3;
        end
        default: begin
          file_bytes[0] = 8'd0;
          file_bytes[1] = 8'd0;
          file_bytes[2] = TGA_RGB;
        end
      endcase
      // a trailing JPEG stream checks format precedence and fallback
      if ($urandom_range(0, 3) == 0) append_jpeg_stream();
    end else if (kind <= 7) begin
      append_jpeg_stream();
      if ($urandom_range(0, 4) == 0) begin
        cut = file_bytes.size() - $urandom_range(1, 10);
        if (cut < 1) cut = 1;
        while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end
    end else begin
      // noise, often opening like one of the signatures
      n = $urandom_range(1, 40);
      repeat (n) file_bytes.push_back(8'($urandom));
      case ($urandom_range(0, 7))
        0: file_bytes[0] = PNG_SIG0;
        1: file_bytes[0] = BMP_SIG0;
        2: file_bytes[0] = DDS_SIG0;
        3: file_bytes[0] = 8'd0;
        4: file_bytes[0] = JPG_MARK;
        default: ;
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stream driver
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      stream_if.valid <= 1'b0;
      stream_gap <= 0;
    end else if (!stream_if.valid || stream_if.ready) begin
      if (stream_gap != 0) begin
        stream_if.valid <= 1'b0;
        stream_gap <= stream_gap - 1;
      end else if (pending_bytes.size() != 0) begin
        stream_if.payload <= pending_bytes.pop_front();
        stream_if.valid <= 1'b1;
        stream_gap <= draw_wait(stream_calm);
      end else begin
        stream_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on byte beats, check report beats, pace report ready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      clear_sniff_state();
      report_if.ready <= 1'b0;
      report_hold <= 0;
    end else begin
      if (stream_if.valid && stream_if.ready)
        sniff_byte(stream_if.payload.data_byte, stream_if.payload.last_byte);
      if (report_if.valid && report_if.ready) begin
        check_report(report_if.payload);
        stall_draw = draw_wait(report_calm);
        report_hold <= stall_draw;
        report_if.ready <= (stall_draw == 0);
      end else if (report_if.valid && !report_if.ready) begin
        // stall counts only while a report is offered
        if (report_hold <= 1) report_if.ready <= 1'b1;
        if (report_hold != 0) report_hold <= report_hold - 1;
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (stream_if.valid && stream_if.ready) || (report_if.valid && report_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int random_items;
    mismatches = 0;
    reports_seen = 0;
    stream_calm = 0;
    report_calm = 0;
    idle_cycles = 0;

    // directed: one-byte and two-byte files, a PNG signature with no body,
    // and a minimal TGA with all-ones fields
    file_bytes = '{8'd7};
    push_file();
    file_bytes = '{PNG_SIG0, PNG_SIG1};
    push_file();
    file_bytes = '{PNG_SIG0, PNG_SIG1, PNG_SIG2};
    push_file();
    file_bytes = '{8'd0, 8'd0, TGA_RGB};
    repeat (15) file_bytes.push_back(8'hFF);
    push_file();

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      build_random_file();
      random_items += file_bytes.size();
      push_file();
    end

    while (pending_bytes.size() != 0 || stream_if.valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_reports.size() != 0)
      report_mismatch($sformatf("%0d reports never arrived", expected_reports.size()));
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
